// ===== rtl/u8dec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dec_pkg: shared types and constants of the UTF-8 code point decoder
// Byte class masks, the decoder state word and the result word.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned CONT_W = 6;

  // lead and continuation byte classes: (byte & mask) == value
  localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
  localparam logic [BYTE_W-1:0] ASCII_VAL  = 8'h00;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_VAL  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_VAL  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_VAL  = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_VAL   = 8'h80;

  // payload bits carried by each byte kind
  localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;
  localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;

  // number of continuation bytes still owed
  localparam logic [1:0] OWE_NONE  = 2'd0;
  localparam logic [1:0] OWE_ONE   = 2'd1;
  localparam logic [1:0] OWE_TWO   = 2'd2;
  localparam logic [1:0] OWE_THREE = 2'd3;

  typedef struct packed {
    logic [1:0]      remaining;
    logic            broken;
    logic [CP_W-1:0] partial;
  } dec_state_t;

  typedef struct packed {
    logic            symbol_valid;
    logic [CP_W-1:0] code_point;
    logic            text_done;
  } dec_result_t;

endpackage

// ===== rtl/u8dec_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dec_step: one byte of UTF-8 decoding
// Combinational update of the decoder state and the result for one byte.
// ----------------------------------------------------------------------------
module u8dec_step
  import u8dec_pkg::*;
(
  input  dec_state_t        state_cur,
  input  logic [BYTE_W-1:0] text_byte,
  input  logic              end_of_text,
  output dec_state_t        state_next,
  output dec_result_t       result
);

  dec_state_t      st;
  logic            emit;
  logic [CP_W-1:0] cp;
  logic [1:0]      owe_dec;

  assign owe_dec = state_cur.remaining - 2'd1;

  // lead byte decode or continuation accumulate
  always_comb begin
    st   = state_cur;
    emit = 1'b0;
    cp   = '0;
    if (state_cur.remaining == OWE_NONE) begin
      if ((text_byte & ASCII_MASK) == ASCII_VAL) begin
        emit = 1'b1;
        cp   = CP_W'(text_byte);
      end else if ((text_byte & LEAD2_MASK) == LEAD2_VAL) begin
        st.partial   = CP_W'(text_byte & LEAD2_BITS);
        st.remaining = OWE_ONE;
        st.broken    = 1'b0;
      end else if ((text_byte & LEAD3_MASK) == LEAD3_VAL) begin
        st.partial   = CP_W'(text_byte & LEAD3_BITS);
        st.remaining = OWE_TWO;
        st.broken    = 1'b0;
      end else if ((text_byte & LEAD4_MASK) == LEAD4_VAL) begin
        st.partial   = CP_W'(text_byte & LEAD4_BITS);
        st.remaining = OWE_THREE;
        st.broken    = 1'b0;
      end
    end else begin
      if ((text_byte & CONT_MASK) != CONT_VAL) begin
        st.broken = 1'b1;
      end else if (!state_cur.broken) begin
        st.partial = {state_cur.partial[CP_W-CONT_W-1:0], text_byte[CONT_W-1:0]};
      end
      st.remaining = owe_dec;
      if (owe_dec == OWE_NONE) begin
        emit = !st.broken;
        cp   = st.broken ? '0 : st.partial;
        st   = '0;
      end
    end
    // end of text drops any open sequence
    if (end_of_text) begin
      st = '0;
    end
  end

  assign state_next          = st;
  assign result.symbol_valid = emit;
  assign result.code_point   = cp;
  assign result.text_done    = end_of_text;

endmodule

// ===== rtl/utf8_code_point_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_code_point_decoder: lenient byte-wide UTF-8 decoder
// Turns a byte stream into code points, one result word per input byte.
// ----------------------------------------------------------------------------
// Takes one byte per cycle unless in_stall is high and returns exactly one
// result word per byte: symbol_valid marks the byte that completes a code
// point, code_point is zero otherwise, and text_done echoes end_of_text.
// The per-byte state step is a single short combinational pass between the
// state registers and the output register; a two-entry output stage (result
// register plus skid register) keeps the input open for one more byte while
// the output is stalled, so in_stall rises only once a stall on the output
// has left both entries full. Invalid lead bytes, broken sequences and
// sequences cut off by end of text produce results with symbol_valid low.
// Overlong forms, surrogates and values above 0x10FFFF are passed through.
module utf8_code_point_decoder
  import u8dec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_text_byte,
  input  logic              in_end_of_text,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_symbol_valid,
  output logic [CP_W-1:0]   out_code_point,
  output logic              out_text_done
);

  dec_state_t  state_r, state_nxt;
  dec_result_t step_res;
  dec_result_t out_word_r, out_word_nxt;
  dec_result_t skid_word_r, skid_word_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic        in_fire, out_fire, out_free;

  // decode step
  u8dec_step u_step (
    .state_cur  (state_r),
    .text_byte  (in_text_byte),
    .end_of_text(in_end_of_text),
    .state_next (state_nxt),
    .result     (step_res)
  );

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || out_fire;

  // output register and skid register control
  always_comb begin
    out_word_nxt   = out_word_r;
    out_valid_nxt  = out_valid_r;
    skid_word_nxt  = skid_word_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_word_nxt   = skid_word_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_word_nxt  = step_res;
        out_valid_nxt = in_fire;
      end
    end else if (in_fire) begin
      skid_word_nxt  = step_res;
      skid_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_symbol_valid = out_word_r.symbol_valid;
  assign out_code_point   = out_word_r.code_point;
  assign out_text_done    = out_word_r.text_done;

endmodule

// ===== rtl/u8dec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dec_checker: port-level checks of the UTF-8 code point decoder
// Watches the top level's ports only; bound to every instance.
// ----------------------------------------------------------------------------
module u8dec_checker
  import u8dec_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [BYTE_W-1:0] in_text_byte,
  input logic              in_end_of_text,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_symbol_valid,
  input logic [CP_W-1:0]   out_code_point,
  input logic              out_text_done
);

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_text_byte)
      && $stable(in_end_of_text))
    else $error("stalled input word changed");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol_valid)
      && $stable(out_code_point) && $stable(out_text_done))
    else $error("stalled result word changed");

  // no code point without a symbol
  a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_symbol_valid |-> out_code_point == '0)
    else $error("code point set on a word without a symbol");

  // input stalls only while a word is pending on the output
  a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // the skid fills only from a byte taken while the output was stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && out_valid && out_stall))
    else $error("input stall without an output stall");

endmodule

bind utf8_code_point_decoder u8dec_checker u_u8dec_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_text_byte    (in_text_byte),
  .in_end_of_text  (in_end_of_text),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_symbol_valid(out_symbol_valid),
  .out_code_point  (out_code_point),
  .out_text_done   (out_text_done)
);
